[rtl/eida_pkg.sv]
// Package for the entity ID allocator with its component-mask table.
// Holds sizing constants, operation and status codes, and the request and
// result structs. No dependencies.
package eida_pkg;

  // Sizing of the ID space and the mask table.
  localparam int ENTITY_COUNT = 64;
  localparam int ID_W         = 6;
  localparam int COUNT_W      = 7;
  localparam int MASK_BITS    = 32;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;

  localparam logic [ID_W-1:0] ID_MAX = ID_W'(ENTITY_COUNT - 1);

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GET     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_LIVING = 2'd2;

  // One request.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [ID_W-1:0]      entity_id;
    logic [MASK_BITS-1:0] mask_value;
  } eida_req_t;

  // One result.
  typedef struct packed {
    logic [ID_W-1:0]      result_id;
    logic [MASK_BITS-1:0] result_mask;
    logic [STATUS_W-1:0]  status;
    logic                 match_valid;
    logic                 last_result;
    logic [COUNT_W-1:0]   living_total;
  } eida_result_t;

endpackage

[rtl/entity_id_allocator_signature_table.sv]
// Entity ID allocator: a first-in first-out free list of IDs with a mask table.
// Create, destroy, set and get pass through a single execute state while busy; the result strobes in the next cycle.
// A query is busy while it reads and compares one mask per cycle over the whole ID space,
// then passes through a closing state; the last result strobes in the cycle after busy falls.
// Reset is synchronous; afterwards an init pass fills the free list and busy stays high.
// The receiver cannot stall: each result strobes for exactly one cycle.
module entity_id_allocator_signature_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  eida_pkg::eida_req_t     cmd,
  output logic                    result_valid,
  output eida_pkg::eida_result_t  result
);
  import eida_pkg::*;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_QEND = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [ID_W-1:0]         init_idx, init_idx_next;
  logic [ID_W-1:0]         free_head, free_head_next;
  logic [ID_W-1:0]         free_tail, free_tail_next;
  logic [COUNT_W-1:0]      free_count, free_count_next;
  logic [COUNT_W-1:0]      living_count, living_count_next;
  logic [ENTITY_COUNT-1:0] living_flags, living_flags_next;
  logic [ENTITY_COUNT-1:0] mask_valid, mask_valid_next;
  logic [ID_W-1:0]         cmp_idx, cmp_idx_next;
  logic                    pend_valid, pend_valid_next;
  logic [ID_W-1:0]         pend_id, pend_id_next;
  eida_req_t               req, req_next;
  eida_result_t            result_next;
  logic                    result_valid_next;

  // Memory ports.
  logic [ID_W-1:0]      queue_mem [ENTITY_COUNT];
  logic [MASK_BITS-1:0] mask_mem  [ENTITY_COUNT];
  logic                 q_we;
  logic [ID_W-1:0]      q_waddr;
  logic [ID_W-1:0]      q_wdata;
  logic [ID_W-1:0]      q_rdata;
  logic                 m_we;
  logic [ID_W-1:0]      m_raddr;
  logic [MASK_BITS-1:0] m_rdata;
  logic                 m_rvalid;
  logic [MASK_BITS-1:0] m_eff;
  logic                 hit;
  logic                 accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // The mask read address follows the request in idle and the scan otherwise.
  always_comb begin
    if (state == ST_IDLE) begin
      m_raddr = (cmd.mode == MODE_QUERY) ? '0 : cmd.entity_id;
    end else begin
      m_raddr = cmp_idx + ID_W'(1);
    end
  end

  // A mask never written since reset or destroy reads as zero.
  assign m_eff = m_rvalid ? m_rdata : '0;
  assign hit   = ((m_eff & req.mask_value) == req.mask_value);

  // Free-list memory: one write port, registered read of the head slot.
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (accept) begin
      q_rdata <= queue_mem[free_head];
    end
  end

  // Mask memory with registered read data and the entry's valid bit.
  always_ff @(posedge clk) begin
    if (m_we) begin
      mask_mem[req.entity_id] <= req.mask_value;
    end
    m_rdata  <= mask_mem[m_raddr];
    m_rvalid <= mask_valid[m_raddr];
  end

  // Sequencer and operation logic.
  always_comb begin
    state_next        = state;
    init_idx_next     = init_idx;
    free_head_next    = free_head;
    free_tail_next    = free_tail;
    free_count_next   = free_count;
    living_count_next = living_count;
    living_flags_next = living_flags;
    mask_valid_next   = mask_valid;
    cmp_idx_next      = cmp_idx;
    pend_valid_next   = pend_valid;
    pend_id_next      = pend_id;
    req_next          = req;
    result_next       = result;
    result_valid_next = 1'b0;
    q_we              = 1'b0;
    q_waddr           = init_idx;
    q_wdata           = init_idx + ID_W'(1);
    m_we              = 1'b0;

    unique case (state)
      ST_INIT: begin
        // Slot i of the free list receives ID i+1; the final slot wraps to zero.
        q_we          = 1'b1;
        init_idx_next = init_idx + ID_W'(1);
        if (init_idx == ID_MAX) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_next = cmd;
          if (cmd.mode == MODE_QUERY) begin
            state_next      = ST_SCAN;
            cmp_idx_next    = '0;
            pend_valid_next = 1'b0;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        state_next             = ST_IDLE;
        result_valid_next      = 1'b1;
        result_next            = '0;
        result_next.last_result = 1'b1;
        result_next.result_id  = req.entity_id;
        unique case (req.mode)
          MODE_CREATE: begin
            if (free_count == '0) begin
              result_next.status    = STATUS_NO_FREE;
              result_next.result_id = '0;
            end else begin
              result_next.result_id = q_rdata;
              free_head_next        = free_head + ID_W'(1);
              free_count_next       = free_count - COUNT_W'(1);
              if (!living_flags[q_rdata]) begin
                living_flags_next[q_rdata] = 1'b1;
                living_count_next          = living_count + COUNT_W'(1);
              end
            end
          end
          MODE_DESTROY: begin
            if (!living_flags[req.entity_id]) begin
              result_next.status = STATUS_NOT_LIVING;
            end else begin
              mask_valid_next[req.entity_id]   = 1'b0;
              living_flags_next[req.entity_id] = 1'b0;
              living_count_next                = living_count - COUNT_W'(1);
              if (free_count < COUNT_W'(ENTITY_COUNT)) begin
                q_we            = 1'b1;
                q_waddr         = free_tail;
                q_wdata         = req.entity_id;
                free_tail_next  = free_tail + ID_W'(1);
                free_count_next = free_count + COUNT_W'(1);
              end
            end
          end
          MODE_SET: begin
            m_we                           = 1'b1;
            mask_valid_next[req.entity_id] = 1'b1;
          end
          MODE_GET: begin
            result_next.result_mask = m_eff;
          end
          default: begin
            // Unused codes change nothing and answer with an empty result.
            result_next.result_id = '0;
          end
        endcase
        result_next.living_total = living_count_next;
      end

      ST_SCAN: begin
        // Each match is held back one step so the final one can carry the last flag.
        cmp_idx_next = cmp_idx + ID_W'(1);
        if (hit) begin
          if (pend_valid) begin
            result_valid_next        = 1'b1;
            result_next              = '0;
            result_next.result_id    = pend_id;
            result_next.match_valid  = 1'b1;
            result_next.living_total = living_count;
          end
          pend_id_next    = cmp_idx;
          pend_valid_next = 1'b1;
        end
        if (cmp_idx == ID_MAX) begin
          state_next = ST_QEND;
        end
      end

      ST_QEND: begin
        // Emit the held match as the final one, or a single empty result.
        state_next               = ST_IDLE;
        result_valid_next        = 1'b1;
        result_next              = '0;
        result_next.last_result  = 1'b1;
        result_next.living_total = living_count;
        if (pend_valid) begin
          result_next.result_id   = pend_id;
          result_next.match_valid = 1'b1;
        end
      end

      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      init_idx     <= '0;
      free_head    <= '0;
      free_tail    <= ID_MAX;
      free_count   <= COUNT_W'(ENTITY_COUNT - 1);
      living_count <= '0;
      living_flags <= '0;
      mask_valid   <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      init_idx     <= init_idx_next;
      free_head    <= free_head_next;
      free_tail    <= free_tail_next;
      free_count   <= free_count_next;
      living_count <= living_count_next;
      living_flags <= living_flags_next;
      mask_valid   <= mask_valid_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req     <= req_next;
    cmp_idx <= cmp_idx_next;
    pend_id <= pend_id_next;
    result  <= result_next;
  end

`ifndef SYNTHESIS
  // Every ID other than zero is either free or living.
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_count} + {1'b0, living_count}) == (COUNT_W + 1)'(ENTITY_COUNT - 1))
    else $error("free and living counts do not add up");

  // A result that is not the last one is always followed by more query work.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_result) |-> busy)
    else $error("intermediate result outside a query");

  // A no-free-ID answer only comes when the free list is empty.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_NO_FREE) |-> (free_count == '0))
    else $error("no-free status with IDs available");

  // Results only follow work in progress.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without an operation in progress");
`endif

endmodule
